### sv/acond_pkg.sv
// acond_pkg: shared types, constants and the sequencer program of the
// audio conditioner. No dependencies; every other file imports it.
`default_nettype none

package acond_pkg;

  // Configuration port
  localparam int CFG_AW = 5;

  localparam logic [2:0] REG_B0   = 3'd0;
  localparam logic [2:0] REG_B1   = 3'd1;
  localparam logic [2:0] REG_B2   = 3'd2;
  localparam logic [2:0] REG_A1   = 3'd3;
  localparam logic [2:0] REG_A2   = 3'd4;
  localparam logic [2:0] REG_RATE = 3'd5;
  localparam logic [2:0] REG_BLEN = 3'd6;

  // Register reset values
  localparam logic [31:0] B0_RESET   = 32'h4000_0000;
  localparam logic [24:0] RATE_RESET = 25'd16777;
  localparam logic [24:0] RATE_ONE   = 25'h100_0000;
  localparam logic [12:0] BLEN_RESET = 13'd512;

  // Signal conditioning constants
  localparam logic [11:0] RAIL_LOW  = 12'd8;
  localparam logic [11:0] RAIL_HIGH = 12'd4087;
  localparam logic [31:0] DC_RESET  = 32'h8000_0000;

  typedef struct packed {
    logic [11:0] raw_code;
    logic        sample_ok;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] audio_sample;
    logic               rail_hit;
    logic               block_clipped;
    logic               block_last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] coef_b0;
    logic signed [31:0] coef_b1;
    logic signed [31:0] coef_b2;
    logic signed [31:0] coef_a1;
    logic signed [31:0] coef_a2;
    logic [24:0]        dc_track_rate;
    logic [12:0]        block_length;
  } cfg_t;

  // Multiplier operand sources
  localparam logic [2:0] SRC_DC = 3'd0;
  localparam logic [2:0] SRC_X  = 3'd1;
  localparam logic [2:0] SRC_X1 = 3'd2;
  localparam logic [2:0] SRC_X2 = 3'd3;
  localparam logic [2:0] SRC_Y1 = 3'd4;
  localparam logic [2:0] SRC_Y2 = 3'd5;

  // Accumulator operations
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  // Jump conditions
  localparam logic [1:0] JC_NEXT     = 2'd0;
  localparam logic [1:0] JC_WAIT_IN  = 2'd1;
  localparam logic [1:0] JC_WAIT_OUT = 2'd2;
  localparam logic [1:0] JC_JUMP     = 2'd3;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_FIN  = 4'd13;

  typedef struct packed {
    logic              take_in;
    logic [2:0]        src;
    logic              hi;
    logic              dc_upd;
    logic              x_calc;
    logic              load_lo;
    logic [1:0]        acc_op;
    logic              finish;
    logic [1:0]        jc;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Control program: one word per step. Each biquad product is split into a low
  // half (16 unsigned bits) and a high half of the operand.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w        = '0;
    w.jc     = JC_NEXT;
    w.src    = SRC_DC;
    w.acc_op = ACC_NONE;
    w.target = STEP_IDLE;
    case (step)
      4'd0: begin
        w.take_in = 1'b1;
        w.jc      = JC_WAIT_IN;
      end
      4'd1: w.src = SRC_DC;
      4'd2: begin
        w.dc_upd = 1'b1;
        w.src    = SRC_X1;
      end
      4'd3: begin
        w.x_calc  = 1'b1;
        w.load_lo = 1'b1;
        w.src     = SRC_X1;
        w.hi      = 1'b1;
      end
      4'd4: begin
        w.acc_op = ACC_LOAD;
        w.src    = SRC_X2;
      end
      4'd5: begin
        w.load_lo = 1'b1;
        w.src     = SRC_X2;
        w.hi      = 1'b1;
      end
      4'd6: begin
        w.acc_op = ACC_ADD;
        w.src    = SRC_Y1;
      end
      4'd7: begin
        w.load_lo = 1'b1;
        w.src     = SRC_Y1;
        w.hi      = 1'b1;
      end
      4'd8: begin
        w.acc_op = ACC_SUB;
        w.src    = SRC_Y2;
      end
      4'd9: begin
        w.load_lo = 1'b1;
        w.src     = SRC_Y2;
        w.hi      = 1'b1;
      end
      4'd10: begin
        w.acc_op = ACC_SUB;
        w.src    = SRC_X;
      end
      4'd11: begin
        w.load_lo = 1'b1;
        w.src     = SRC_X;
        w.hi      = 1'b1;
      end
      4'd12: w.acc_op = ACC_ADD;
      4'd13: begin
        w.finish = 1'b1;
        w.jc     = JC_WAIT_OUT;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jc     = JC_JUMP;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### sv/acond_cfg_regs.sv
// acond_cfg_regs: APB-style register bank holding filter coefficients,
// DC tracking rate and block length. Depends on acond_pkg.
`default_nettype none

module acond_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [acond_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output acond_pkg::cfg_t                   cfg
);
  import acond_pkg::*;

  cfg_t        cfg_r;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  // Take a write transaction in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_b0       <= B0_RESET;
      cfg_r.coef_b1       <= '0;
      cfg_r.coef_b2       <= '0;
      cfg_r.coef_a1       <= '0;
      cfg_r.coef_a2       <= '0;
      cfg_r.dc_track_rate <= RATE_RESET;
      cfg_r.block_length  <= BLEN_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_B0:   cfg_r.coef_b0       <= pwdata;
        REG_B1:   cfg_r.coef_b1       <= pwdata;
        REG_B2:   cfg_r.coef_b2       <= pwdata;
        REG_A1:   cfg_r.coef_a1       <= pwdata;
        REG_A2:   cfg_r.coef_a2       <= pwdata;
        REG_RATE: cfg_r.dc_track_rate <= pwdata[24:0];
        REG_BLEN: cfg_r.block_length  <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_B0:   prdata = cfg_r.coef_b0;
      REG_B1:   prdata = cfg_r.coef_b1;
      REG_B2:   prdata = cfg_r.coef_b2;
      REG_A1:   prdata = cfg_r.coef_a1;
      REG_A2:   prdata = cfg_r.coef_a2;
      REG_RATE: prdata = {7'b0, cfg_r.dc_track_rate};
      REG_BLEN: prdata = {19'b0, cfg_r.block_length};
      default:  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### sv/adc_audio_conditioner_unit.sv
// Audio ADC conditioner: DC removal, biquad filter, Q1.15 output, block
// marking. Depends on acond_pkg and acond_cfg_regs.
//
// Each valid 12-bit ADC code (sample_ok high) runs the program in order: a step
// to take the transaction, twelve program steps through a single shared 34x32
// signed multiplier (one DC-tracking product and ten half products for the
// five biquad taps), and a step to write the result register. The shared
// multiplier sets the number of steps. An item with sample_ok low is taken
// at the idle step and gives no result. The result register frees the input
// side, so the next item is taken while a result waits. Registers, at byte
// address 4*i: b0, b1, b2, a1, a2 (signed Q2.30), dc_track_rate (Q1.24), block_length.
`default_nettype none

module adc_audio_conditioner_unit #(
  parameter int MAX_BLOCK_LENGTH = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [acond_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire acond_pkg::in_item_t          in_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output acond_pkg::out_item_t              out_data
);
  import acond_pkg::*;

  localparam int FILL_W = $clog2(MAX_BLOCK_LENGTH + 1);
  localparam int LEN_W  = (FILL_W > 13) ? FILL_W : 13;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BLOCK_LENGTH);

  cfg_t cfg;

  acond_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer
  logic [STEP_W-1:0] pc_r, pc_nxt;
  ucode_t            uc;
  logic              in_fire, out_free, fin_go;

  // Datapath state
  logic [11:0]        raw_r;
  logic               near_r;
  logic [31:0]        dc_r;
  logic signed [33:0] x_r, x1_r, x2_r;
  logic signed [39:0] y1_r, y2_r;
  logic signed [65:0] prod_r;
  logic signed [49:0] lo_r;
  logic signed [44:0] acc_r, acc_nxt;
  logic [FILL_W-1:0]  fill_r;
  logic               clip_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // Combinational datapath
  logic [31:0]        code;
  logic signed [32:0] diff;
  logic [24:0]        rate_eff;
  logic signed [39:0] v;
  logic signed [31:0] coef;
  logic signed [33:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [65:0] prod_nxt;
  logic signed [57:0] dc_rnd;
  logic signed [33:0] dc_sum;
  logic signed [57:0] term_sum;
  logic signed [43:0] term;
  logic signed [44:0] term_x;
  logic signed [39:0] y_sat;
  logic signed [40:0] y_rnd;
  logic signed [24:0] s_full;
  logic signed [15:0] s_sat;
  logic               near_in;
  logic [LEN_W-1:0]   len_raw, len_eff, fill_inc;
  logic               last, clip_now;

  assign uc       = ucode_rom(pc_r);
  assign in_ready = uc.take_in;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign fin_go   = uc.finish && out_free;

  // Step counter with conditional jumps
  always_comb begin
    pc_nxt = pc_r;
    case (uc.jc)
      JC_NEXT:     pc_nxt = pc_r + 1'b1;
      JC_WAIT_IN:  if (in_fire && in_data.sample_ok) pc_nxt = pc_r + 1'b1;
      JC_WAIT_OUT: if (out_free) pc_nxt = uc.target;
      JC_JUMP:     pc_nxt = uc.target;
      default:     pc_nxt = STEP_IDLE;
    endcase
  end

  // DC tracker operands
  assign code     = {raw_r, 20'b0};
  assign diff     = $signed({1'b0, code}) - $signed({1'b0, dc_r});
  assign rate_eff = (cfg.dc_track_rate > RATE_ONE) ? RATE_ONE : cfg.dc_track_rate;

  // Select multiplier operands
  always_comb begin
    case (uc.src)
      SRC_X:   begin v = 40'(x_r);  coef = cfg.coef_b0; end
      SRC_X1:  begin v = 40'(x1_r); coef = cfg.coef_b1; end
      SRC_X2:  begin v = 40'(x2_r); coef = cfg.coef_b2; end
      SRC_Y1:  begin v = y1_r;      coef = cfg.coef_a1; end
      SRC_Y2:  begin v = y2_r;      coef = cfg.coef_a2; end
      default: begin v = '0;        coef = '0;          end
    endcase
    if (uc.src == SRC_DC) begin
      mul_a = 34'(diff);
      mul_b = {7'b0, rate_eff};
    end else begin
      mul_a = uc.hi ? {{10{v[39]}}, v[39:16]} : {18'b0, v[15:0]};
      mul_b = coef;
    end
  end

  assign prod_nxt = mul_a * mul_b;

  // Rounded DC step and new estimate
  assign dc_rnd = prod_r[57:0] + 58'sd8388608;
  assign dc_sum = $signed({2'b00, dc_r}) + $signed(dc_rnd[57:24]);

  // Join half products into floor(v * c / 2^30)
  assign term_sum = prod_r[57:0] + {{8{lo_r[49]}}, lo_r};
  assign term     = term_sum[57:14];
  assign term_x   = {term[43], term};

  always_comb begin
    case (uc.acc_op)
      ACC_LOAD: acc_nxt = term_x;
      ACC_ADD:  acc_nxt = acc_r + term_x;
      ACC_SUB:  acc_nxt = acc_r - term_x;
      default:  acc_nxt = acc_r;
    endcase
  end

  // Saturate filter output to 40 bits, then round to Q1.15
  always_comb begin
    if ((&acc_r[44:39]) || !(|acc_r[44:39])) begin
      y_sat = acc_r[39:0];
    end else begin
      y_sat = acc_r[44] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
    end
    y_rnd  = $signed({y_sat[39], y_sat}) + 41'sd32768;
    s_full = y_rnd[40:16];
    if ((&s_full[24:15]) || !(|s_full[24:15])) begin
      s_sat = s_full[15:0];
    end else begin
      s_sat = s_full[24] ? 16'sh8000 : 16'sh7fff;
    end
  end

  // Block bookkeeping
  assign near_in  = (in_data.raw_code <= RAIL_LOW) || (in_data.raw_code >= RAIL_HIGH);
  assign len_raw  = LEN_W'(cfg.block_length);
  assign len_eff  = (len_raw == '0) ? LEN_W'(1) : ((len_raw > MAX_LEN) ? MAX_LEN : len_raw);
  assign fill_inc = LEN_W'(fill_r) + LEN_W'(1);
  assign last     = fill_inc >= len_eff;
  assign clip_now = clip_r | near_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_IDLE;
      dc_r        <= DC_RESET;
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
      fill_r      <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (uc.dc_upd) begin
        dc_r <= dc_sum[31:0];
      end
      if (fin_go) begin
        x2_r        <= x1_r;
        x1_r        <= x_r;
        y2_r        <= y1_r;
        y1_r        <= y_sat;
        fill_r      <= last ? '0 : FILL_W'(fill_inc);
        clip_r      <= last ? 1'b0 : clip_now;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      raw_r  <= in_data.raw_code;
      near_r <= near_in;
    end
    prod_r <= prod_nxt;
    if (uc.load_lo) begin
      lo_r <= prod_r[65:16];
    end
    if (uc.x_calc) begin
      x_r <= $signed({2'b00, code}) - $signed({2'b00, dc_r});
    end
    acc_r <= acc_nxt;
    if (fin_go) begin
      out_data_r.audio_sample  <= s_sat;
      out_data_r.rail_hit      <= near_r;
      out_data_r.block_clipped <= clip_now;
      out_data_r.block_last    <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && uc.finish) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result overwritten");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LEN_W'(fill_r) < MAX_LEN)
    else $error("block fill reached maximum without closing block");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_go && last) |=> (fill_r == '0 && !clip_r))
    else $error("block state not cleared after last sample");

  a_skip_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_data.sample_ok) |=> (pc_r == STEP_IDLE))
    else $error("invalid item started the program");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= STEP_FIN)
    else $error("step counter out of program");

endmodule

`default_nettype wire
